>>> hw/rtl/world_to_screen_projection_macros.svh
// assertion macros for the world to screen projection block
`ifndef WORLD_TO_SCREEN_PROJECTION_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_MACROS_SVH

// same-cycle implication
`define WTSP_AST_IMP(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WTSP_AST_NXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/wtsp_pkg.sv
// shared types and constants of the world to screen projection block
package wtsp_pkg;

  localparam int CLW      = 66;
  localparam int NDC_BITS = 50;
  localparam int NW       = NDC_BITS + 3;

  localparam logic OP_PROJECT = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  localparam logic [1:0] LAYOUT_ROW  = 2'd0;
  localparam logic [1:0] LAYOUT_COL  = 2'd1;
  localparam logic [1:0] LAYOUT_AUTO = 2'd2;

  localparam logic [2:0] REG_LAYOUT = 3'd0;
  localparam logic [2:0] REG_DZ01   = 3'd1;
  localparam logic [2:0] REG_YFLIP  = 3'd2;
  localparam logic [2:0] REG_VIEW_X = 3'd3;
  localparam logic [2:0] REG_VIEW_Y = 3'd4;
  localparam logic [2:0] REG_VIEW_W = 3'd5;
  localparam logic [2:0] REG_VIEW_H = 3'd6;

  typedef logic signed [CLW-1:0] clip_t;
  typedef logic [CLW-1:0]        mag_t;
  typedef logic [NDC_BITS-1:0]   quo_t;
  typedef logic signed [NW-1:0]  ndc_t;

  typedef struct packed {
    mag_t rem;
    quo_t low;
    quo_t quo;
  } div_lane_t;

  typedef struct packed {
    logic       tiny;
    logic       clip;
    logic [2:0] neg;
    logic [2:0] cap;
  } lay_flags_t;

  typedef struct packed {
    mag_t                  dvs;
    div_lane_t [2:0]       lane;
  } div_grp_t;

  typedef struct packed {
    logic                  any;
    lay_flags_t [1:0]      fl;
    div_grp_t [1:0]        grp;
  } div_word_t;

  typedef struct packed {
    logic [1:0]         layout;
    logic               dz01;
    logic               yflip;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vw;
    logic signed [31:0] vh;
  } cfg_t;

  typedef struct packed {
    logic        ok;
    logic        clip;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] dz;
  } res_t;

endpackage

>>> hw/rtl/wtsp_if.sv
// input and result channel interfaces
interface wtsp_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [3:0]         entry_index;
  logic signed [31:0] entry_value;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;

  modport source(output valid, opcode, entry_index, entry_value, world_x, world_y, world_z,
                 input ready);
  modport sink(input valid, opcode, entry_index, entry_value, world_x, world_y, world_z,
               output ready);
endinterface

interface wtsp_out_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic               clipped;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] depth;

  modport source(output valid, ok, clipped, screen_x, screen_y, depth, input ready);
  modport sink(input valid, ok, clipped, screen_x, screen_y, depth, output ready);
endinterface

>>> hw/rtl/wtsp_xform.sv
// matrix store, clip space transform and divider setup stages
module wtsp_xform #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wtsp_pkg::cfg_t      cfg,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic                up_op,
  input  logic [3:0]          up_idx,
  input  logic signed [31:0]  up_val,
  input  logic signed [31:0]  up_wx,
  input  logic signed [31:0]  up_wy,
  input  logic signed [31:0]  up_wz,
  output logic                dn_valid,
  input  logic                dn_ready,
  output wtsp_pkg::div_word_t dn_data
);

  localparam int SH   = wtsp_pkg::NDC_BITS - FRAC_BITS;
  localparam int TINY = ((1 << FRAC_BITS) - 1) / 100000;
  localparam int BIG  = (1 << FRAC_BITS) / 1000000;

  logic signed [31:0] mat_r [16];
  logic [15:0]        big_r;
  logic [3:0]         vld_r;
  logic [3:0]         en;
  logic [32:0]        up_mag;
  logic signed [31:0] wv [3];

  logic signed [63:0] prod_nxt [2][4][3];
  logic signed [63:0] prod_r   [2][4][3];
  logic signed [31:0] dc_nxt   [2][4];
  logic signed [31:0] dc_r     [2][4];
  logic [2:0]         any_r;

  wtsp_pkg::clip_t    sum_w    [2][4];
  wtsp_pkg::clip_t    clip_nxt [2][4];
  wtsp_pkg::clip_t    clip_r   [2][4];
  wtsp_pkg::mag_t     mag_nxt  [2][4];
  wtsp_pkg::mag_t     mag_r    [2][4];
  logic               sgn_r    [2][4];

  wtsp_pkg::mag_t      hd [2][3];
  logic                zc [2];
  wtsp_pkg::div_word_t word_nxt;
  wtsp_pkg::div_word_t word_r;

  assign wv[0] = up_wx;
  assign wv[1] = up_wy;
  assign wv[2] = up_wz;

  assign en[3]    = !vld_r[3] || dn_ready;
  assign en[2]    = !vld_r[2] || en[3];
  assign en[1]    = !vld_r[1] || en[2];
  assign en[0]    = !vld_r[0] || en[1];
  assign up_ready = en[0];
  assign dn_valid = vld_r[3];
  assign dn_data  = word_r;

  assign up_mag = up_val[31] ? -{up_val[31], up_val} : {1'b0, up_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      big_r <= '0;
      for (int k = 0; k < 16; k++) mat_r[k] <= '0;
    end else begin
      if (en[0]) vld_r[0] <= up_valid && (up_op == wtsp_pkg::OP_PROJECT);
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
      if (en[3]) vld_r[3] <= vld_r[2];
      if (up_valid && up_ready && (up_op == wtsp_pkg::OP_LOAD)) begin
        mat_r[up_idx] <= up_val;
        big_r[up_idx] <= up_mag > 33'(BIG);
      end
    end
  end

  // clip space products for both layouts
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int r = 0; r < 4; r++) begin
        for (int i = 0; i < 3; i++) begin
          prod_nxt[l][r][i] = wv[i] * mat_r[(l == 0) ? 4'(r * 4 + i) : 4'(i * 4 + r)];
        end
        dc_nxt[l][r] = mat_r[(l == 0) ? 4'(r * 4 + 3) : 4'(12 + r)];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int r = 0; r < 4; r++) begin
        sum_w[l][r] = wtsp_pkg::clip_t'(prod_r[l][r][0]) + wtsp_pkg::clip_t'(prod_r[l][r][1])
                    + wtsp_pkg::clip_t'(prod_r[l][r][2]);
        clip_nxt[l][r] = (sum_w[l][r] >>> FRAC_BITS) + wtsp_pkg::clip_t'(dc_r[l][r]);
        mag_nxt[l][r]  = clip_r[l][r][wtsp_pkg::CLW-1] ? wtsp_pkg::mag_t'(-clip_r[l][r])
                                                        : wtsp_pkg::mag_t'(clip_r[l][r]);
      end
    end
  end

  // clip tests and divider seeds
  always_comb begin
    word_nxt     = '0;
    word_nxt.any = any_r[2];
    for (int l = 0; l < 2; l++) begin
      zc[l] = cfg.dz01 ? (((mag_r[l][2] != '0) && (sgn_r[l][2] != sgn_r[l][3]))
                          || (mag_r[l][2] > mag_r[l][3]))
                       : (mag_r[l][2] > mag_r[l][3]);
      word_nxt.grp[l].dvs  = mag_r[l][3];
      word_nxt.fl[l].tiny  = mag_r[l][3] <= wtsp_pkg::mag_t'(TINY);
      word_nxt.fl[l].clip  = (mag_r[l][0] > mag_r[l][3]) || (mag_r[l][1] > mag_r[l][3])
                             || zc[l] || sgn_r[l][3];
      for (int i = 0; i < 3; i++) begin
        hd[l][i]                     = mag_r[l][i] >> SH;
        word_nxt.fl[l].neg[i]        = sgn_r[l][i] ^ sgn_r[l][3];
        word_nxt.fl[l].cap[i]        = hd[l][i] >= mag_r[l][3];
        word_nxt.grp[l].lane[i].rem  = hd[l][i];
        word_nxt.grp[l].lane[i].low  = wtsp_pkg::quo_t'(mag_r[l][i] << FRAC_BITS);
        word_nxt.grp[l].lane[i].quo  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r   <= prod_nxt;
      dc_r     <= dc_nxt;
      any_r[0] <= |big_r;
    end
    if (en[1]) begin
      clip_r   <= clip_nxt;
      any_r[1] <= any_r[0];
    end
    if (en[2]) begin
      mag_r    <= mag_nxt;
      any_r[2] <= any_r[1];
      for (int l = 0; l < 2; l++) begin
        for (int r = 0; r < 4; r++) sgn_r[l][r] <= clip_r[l][r][wtsp_pkg::CLW-1];
      end
    end
    if (en[3]) word_r <= word_nxt;
  end

endmodule

>>> hw/rtl/wtsp_div_step.sv
// one restoring division step for all six quotient lanes
module wtsp_div_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  wtsp_pkg::div_word_t up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output wtsp_pkg::div_word_t dn_data
);

  logic                    vld_r;
  logic [wtsp_pkg::CLW:0]  t   [2][3];
  logic                    ge  [2][3];
  wtsp_pkg::div_word_t     nxt;
  wtsp_pkg::div_word_t     data_r;

  assign up_ready = !vld_r || dn_ready;
  assign dn_valid = vld_r;
  assign dn_data  = data_r;

  always_comb begin
    nxt = up_data;
    for (int l = 0; l < 2; l++) begin
      for (int i = 0; i < 3; i++) begin
        t[l][i]  = {up_data.grp[l].lane[i].rem,
                    up_data.grp[l].lane[i].low[wtsp_pkg::NDC_BITS-1]};
        ge[l][i] = t[l][i] >= {1'b0, up_data.grp[l].dvs};
        nxt.grp[l].lane[i].rem = ge[l][i]
          ? wtsp_pkg::mag_t'(t[l][i] - {1'b0, up_data.grp[l].dvs})
          : wtsp_pkg::mag_t'(t[l][i]);
        nxt.grp[l].lane[i].low = up_data.grp[l].lane[i].low << 1;
        nxt.grp[l].lane[i].quo = {up_data.grp[l].lane[i].quo[wtsp_pkg::NDC_BITS-2:0],
                                  ge[l][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) data_r <= nxt;
  end

endmodule

>>> hw/rtl/wtsp_view.sv
// quotient signing, viewport mapping, saturation and layout selection stages
module wtsp_view #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wtsp_pkg::cfg_t      cfg,
  input  logic                up_valid,
  output logic                up_ready,
  input  wtsp_pkg::div_word_t up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output wtsp_pkg::res_t      dn_data
);

  localparam int ND = wtsp_pkg::NDC_BITS;
  localparam int MW = ND + 32;
  localparam int VW = MW + 2;
  localparam int SB = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  localparam wtsp_pkg::ndc_t ONE_N = wtsp_pkg::ndc_t'(1) << FRAC_BITS;
  localparam wtsp_pkg::ndc_t HI_N  = (wtsp_pkg::ndc_t'(1) << (SB - 1)) - wtsp_pkg::ndc_t'(1);
  localparam wtsp_pkg::ndc_t LO_N  = -(wtsp_pkg::ndc_t'(1) << (SB - 1));
  localparam logic signed [VW-1:0] HI_V = (VW'(1) << (SB - 1)) - VW'(1);
  localparam logic signed [VW-1:0] LO_V = -(VW'(1) << (SB - 1));
  localparam logic signed [31:0]   ONE32 = 32'(1) << FRAC_BITS;

  typedef struct packed {
    logic             any;
    logic [1:0]       tiny;
    logic [1:0]       clip;
    logic [1:0]       oz;
    logic [1:0][31:0] dz;
  } side_t;

  logic [7:0] vld_r;
  logic [7:0] en;
  side_t      sd_r [7];

  wtsp_pkg::ndc_t     n_nxt  [2][3];
  wtsp_pkg::ndc_t     n_r    [2][3];
  logic [ND:0]        nabs   [2][3];
  wtsp_pkg::ndc_t     u_nxt  [2][2];
  wtsp_pkg::ndc_t     u_r    [2][2];
  logic [ND:0]        au_r   [2][2];
  logic               un_r   [3][2][2];
  logic [ND-1:0]      ph_r   [2][2];
  logic [62:0]        pl_r   [2][2];
  logic [MW-1:0]      m_r    [2][2];
  logic signed [VW-1:0] sm   [2][2];
  logic signed [VW-1:0] sv_nxt [2][2];
  logic signed [VW-1:0] sv_r [2][2];
  logic               ov     [2][2];
  logic               okl    [2];
  wtsp_pkg::res_t     res_nxt [2];
  wtsp_pkg::res_t     res_r   [2];
  wtsp_pkg::res_t     sel;
  wtsp_pkg::res_t     out_r;
  side_t              sd0_nxt;
  side_t              sd1_nxt;
  logic               setup;

  always_comb begin
    en[7] = !vld_r[7] || dn_ready;
    for (int k = 6; k >= 0; k--) en[k] = !vld_r[k] || en[k+1];
  end
  assign up_ready = en[0];
  assign dn_valid = vld_r[7];
  assign dn_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= up_valid;
      for (int k = 1; k < 8; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // signed normalized values
  always_comb begin
    sd0_nxt = '0;
    sd0_nxt.any = up_data.any;
    for (int l = 0; l < 2; l++) begin
      sd0_nxt.tiny[l] = up_data.fl[l].tiny;
      sd0_nxt.clip[l] = up_data.fl[l].clip;
      for (int i = 0; i < 3; i++) begin
        nabs[l][i]  = up_data.fl[l].cap[i] ? {1'b1, {ND{1'b0}}}
                                           : {1'b0, up_data.grp[l].lane[i].quo};
        n_nxt[l][i] = up_data.fl[l].neg[i] ? -wtsp_pkg::ndc_t'(nabs[l][i])
                                           : wtsp_pkg::ndc_t'(nabs[l][i]);
      end
    end
  end

  // viewport offsets and depth range
  always_comb begin
    sd1_nxt = sd_r[0];
    for (int l = 0; l < 2; l++) begin
      u_nxt[l][0]   = n_r[l][0] + ONE_N;
      u_nxt[l][1]   = cfg.yflip ? (n_r[l][1] + ONE_N) : (ONE_N - n_r[l][1]);
      sd1_nxt.oz[l] = (n_r[l][2] > HI_N) || (n_r[l][2] < LO_N);
      sd1_nxt.dz[l] = n_r[l][2][31:0];
    end
  end

  // placement sums
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int j = 0; j < 2; j++) begin
        sm[l][j]     = $signed({2'b00, m_r[l][j]});
        sv_nxt[l][j] = ((j == 0) ? VW'(cfg.vx) : VW'(cfg.vy))
                       + (un_r[2][l][j] ? -sm[l][j] : sm[l][j]);
      end
    end
  end

  // range overflow and failure handling
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int j = 0; j < 2; j++) ov[l][j] = (sv_r[l][j] > HI_V) || (sv_r[l][j] < LO_V);
      okl[l] = !sd_r[5].tiny[l] && !(ov[l][0] || ov[l][1] || sd_r[5].oz[l]);
      if (okl[l]) begin
        res_nxt[l].ok   = 1'b1;
        res_nxt[l].clip = sd_r[5].clip[l];
        res_nxt[l].sx   = sv_r[l][0][31:0];
        res_nxt[l].sy   = sv_r[l][1][31:0];
        res_nxt[l].dz   = sd_r[5].dz[l];
      end else begin
        res_nxt[l] = '0;
      end
    end
  end

  // layout choice
  always_comb begin
    setup = sd_r[6].any && (cfg.vw > ONE32) && (cfg.vh > ONE32);
    unique case (cfg.layout)
      wtsp_pkg::LAYOUT_ROW: sel = res_r[0];
      wtsp_pkg::LAYOUT_COL: sel = res_r[1];
      default: begin
        if (res_r[0].ok && !res_r[0].clip) sel = res_r[0];
        else if (res_r[1].ok)              sel = res_r[1];
        else                               sel = res_r[0];
      end
    endcase
    if (!setup) sel = '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n_r     <= n_nxt;
      sd_r[0] <= sd0_nxt;
    end
    if (en[1]) begin
      u_r     <= u_nxt;
      sd_r[1] <= sd1_nxt;
    end
    if (en[2]) begin
      sd_r[2] <= sd_r[1];
      for (int l = 0; l < 2; l++) begin
        for (int j = 0; j < 2; j++) begin
          un_r[0][l][j] <= u_r[l][j][wtsp_pkg::NW-1];
          au_r[l][j]    <= u_r[l][j][wtsp_pkg::NW-1] ? (ND+1)'(-u_r[l][j])
                                                     : (ND+1)'(u_r[l][j]);
        end
      end
    end
    if (en[3]) begin
      sd_r[3] <= sd_r[2];
      un_r[1] <= un_r[0];
      for (int l = 0; l < 2; l++) begin
        ph_r[l][0] <= au_r[l][0][ND:32] * cfg.vw[30:0];
        pl_r[l][0] <= au_r[l][0][31:0]  * cfg.vw[30:0];
        ph_r[l][1] <= au_r[l][1][ND:32] * cfg.vh[30:0];
        pl_r[l][1] <= au_r[l][1][31:0]  * cfg.vh[30:0];
      end
    end
    if (en[4]) begin
      sd_r[4] <= sd_r[3];
      un_r[2] <= un_r[1];
      for (int l = 0; l < 2; l++) begin
        for (int j = 0; j < 2; j++) begin
          m_r[l][j] <= ({ph_r[l][j], 32'b0} + MW'(pl_r[l][j])) >> (FRAC_BITS + 1);
        end
      end
    end
    if (en[5]) begin
      sd_r[5] <= sd_r[4];
      sv_r    <= sv_nxt;
    end
    if (en[6]) begin
      sd_r[6] <= sd_r[5];
      res_r   <= res_nxt;
    end
    if (en[7]) out_r <= sel;
  end

endmodule

>>> hw/rtl/world_to_screen_projection.sv
// top level of the world to screen projection block
//
//  channel | direction | contents
//  in_ch   | in        | opcode, entry_index, entry_value, world_x/y/z
//  out_ch  | out       | ok, clipped, screen_x, screen_y, depth
//  cfg_*   | in        | register write: cfg_we, cfg_index, cfg_wdata
//
// one transaction per cycle while out_ch does not stall; a project transaction returns its result
// through 62 register stages: 4 transform, 50 one-bit divider, 8 mapping
// a load writes the matrix at acceptance and yields no result
// synchronous reset clears the matrix, empties every stage and sets auto layout
// each stage holds while the next one is full, so bubbles close up under stalls
module world_to_screen_projection #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  wtsp_in_if.sink           in_ch,
  wtsp_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);

  localparam int NSTEP = wtsp_pkg::NDC_BITS;

  logic [1:0]         layout_r;
  logic               dz01_r;
  logic               yflip_r;
  logic signed [31:0] vx_r;
  logic signed [31:0] vy_r;
  logic signed [31:0] vw_r;
  logic signed [31:0] vh_r;
  wtsp_pkg::cfg_t     cfg;

  logic                dv [NSTEP+1];
  logic                dr [NSTEP+1];
  wtsp_pkg::div_word_t dd [NSTEP+1];
  wtsp_pkg::res_t      res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= wtsp_pkg::LAYOUT_AUTO;
      dz01_r   <= 1'b0;
      yflip_r  <= 1'b0;
      vx_r     <= '0;
      vy_r     <= '0;
      vw_r     <= '0;
      vh_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wtsp_pkg::REG_LAYOUT: layout_r <= cfg_wdata[1:0];
        wtsp_pkg::REG_DZ01:   dz01_r   <= cfg_wdata[0];
        wtsp_pkg::REG_YFLIP:  yflip_r  <= cfg_wdata[0];
        wtsp_pkg::REG_VIEW_X: vx_r     <= cfg_wdata;
        wtsp_pkg::REG_VIEW_Y: vy_r     <= cfg_wdata;
        wtsp_pkg::REG_VIEW_W: vw_r     <= cfg_wdata;
        wtsp_pkg::REG_VIEW_H: vh_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.layout = layout_r;
  assign cfg.dz01   = dz01_r;
  assign cfg.yflip  = yflip_r;
  assign cfg.vx     = vx_r;
  assign cfg.vy     = vy_r;
  assign cfg.vw     = vw_r;
  assign cfg.vh     = vh_r;

  wtsp_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_op    (in_ch.opcode),
    .up_idx   (in_ch.entry_index),
    .up_val   (in_ch.entry_value),
    .up_wx    (in_ch.world_x),
    .up_wy    (in_ch.world_y),
    .up_wz    (in_ch.world_z),
    .dn_valid (dv[0]),
    .dn_ready (dr[0]),
    .dn_data  (dd[0])
  );

  for (genvar g = 0; g < NSTEP; g++) begin : g_div
    wtsp_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv[g]),
      .up_ready (dr[g]),
      .up_data  (dd[g]),
      .dn_valid (dv[g+1]),
      .dn_ready (dr[g+1]),
      .dn_data  (dd[g+1])
    );
  end

  wtsp_view #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_view (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (dv[NSTEP]),
    .up_ready (dr[NSTEP]),
    .up_data  (dd[NSTEP]),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_data  (res)
  );

  assign out_ch.ok       = res.ok;
  assign out_ch.clipped  = res.clip;
  assign out_ch.screen_x = res.sx;
  assign out_ch.screen_y = res.sy;
  assign out_ch.depth    = res.dz;

endmodule

>>> hw/rtl/wtsp_checker.sv
// port level assertions for the world to screen projection block
`include "world_to_screen_projection_macros.svh"

module wtsp_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_ok,
  input logic        out_clipped,
  input logic [31:0] out_sx,
  input logic [31:0] out_sy,
  input logic [31:0] out_depth
);

  localparam logic signed [31:0] ONE = 32'(1) << FRAC_BITS;

  // failed transactions carry no coordinates
  `WTSP_AST_IMP(a_fail_zero, clk, !rst_n, out_valid && !out_ok, !out_clipped && out_sx == '0 && out_sy == '0 && out_depth == '0, "failed result carries data")

  // unclipped results have depth within one
  `WTSP_AST_IMP(a_depth_range, clk, !rst_n, out_valid && out_ok && !out_clipped, $signed(out_depth) <= ONE && $signed(out_depth) >= -ONE, "unclipped depth out of range")

  // reset empties the pipeline
  `WTSP_AST_NXT(a_reset_idle, clk, 1'b0, !rst_n, !out_valid, "result after reset")

  // a stalled result holds
  `WTSP_AST_NXT(a_stall_hold, clk, !rst_n, out_valid && !out_ready, out_valid && $stable(out_sx) && $stable(out_sy) && $stable(out_depth), "stalled result changed")

endmodule

bind world_to_screen_projection wtsp_checker #(.FRAC_BITS(FRAC_BITS)) u_wtsp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_ok      (out_ch.ok),
  .out_clipped (out_ch.clipped),
  .out_sx      (out_ch.screen_x),
  .out_sy      (out_ch.screen_y),
  .out_depth   (out_ch.depth)
);
